[rtl/flr_pkg.sv]
// ----------------------------------------------------------------------------
// flr_pkg
// shared types and constants of the low-pass filter and linear resampler
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int TAPS_DEF          = 32;
    localparam int FRAME_LEN_DEF     = 256;
    localparam int RESAMPLED_LEN_DEF = 92;

    localparam logic        REQ_SAMPLE     = 1'b0;
    localparam logic        REQ_COEF       = 1'b1;

    localparam logic        REG_ENABLE     = 1'b0;
    localparam logic        REG_STEP_RATIO = 1'b1;

    localparam logic        ENABLE_RST     = 1'b1;
    localparam logic [19:0] STEP_RATIO_RST = 20'd181043;
    localparam logic [19:0] STEP_RATIO_MIN = 20'h10000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_INT1,
        ST_INT2,
        ST_INT3,
        ST_OUT,
        ST_FIN
    } t_state;

endpackage

[rtl/fir_lowpass_linear_resampler_top.sv]
// ----------------------------------------------------------------------------
// fir_lowpass_linear_resampler_top
// fir low-pass filter with one shared multiply-accumulate unit, followed by a
// per-frame linear-interpolation resampler
// ----------------------------------------------------------------------------
// flow: a sample beat runs TAPS tap products through the single shared multiplier,
//   then rounding and, for an emitting beat, two interpolation products and the output
//   register; s_axis_tready stays low until it is done, longer while an output beat
//   waits; a coefficient or ignored beat leaves the block idle and ready
// reset: synchronous, active low; a clearing pass zeroes the
//   coefficient and delay line memories while s_axis_tready stays low
module fir_lowpass_linear_resampler_top
    import flr_pkg::*;
#(
    parameter int TAPS          = TAPS_DEF,
    parameter int FRAME_LEN     = FRAME_LEN_DEF,
    parameter int RESAMPLED_LEN = RESAMPLED_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // coef_index[4:0], value[20:5], zero fill
    input  logic        s_axis_tuser,   // req_type[0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // resampled_sample[15:0]
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int KW    = $clog2(TAPS + 1);
    localparam int FW    = $clog2(FRAME_LEN);
    localparam int POS_W = ((FW > 4) ? FW : 4) + 17;
    localparam int IP_W  = POS_W - 16;
    localparam int CW    = (RESAMPLED_LEN > 1) ? $clog2(RESAMPLED_LEN + 1) : 1;
    localparam int ACC_W = (32 + AW > 35) ? 32 + AW : 35;

    localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] S_MIN = -ACC_W'(32768);

    t_state                   r_state, n_state;
    logic [KW-1:0]            r_k, n_k;
    logic [AW-1:0]            r_wp, n_wp, r_rp, n_rp;
    logic                     r_rd_vld, n_rd_vld, r_prod_vld, n_prod_vld;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [34:0]       r_prod;
    logic signed [15:0]       r_cur, n_cur, r_prev, n_prev;
    logic [FW-1:0]            r_fidx, n_fidx;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_enable, n_enable;
    logic [19:0]              r_ratio, n_ratio;
    logic                     r_m_valid, n_m_valid;
    logic [15:0]              r_m_data, n_m_data;
    logic                     r_m_last, n_m_last;

    logic signed [15:0]       r_coef_mem [TAPS];
    logic signed [15:0]       r_dl_mem   [TAPS];
    logic signed [15:0]       r_coef_rd, r_dl_rd;

    logic                     cf_we, dl_we;
    logic [AW-1:0]            cf_waddr, dl_waddr;
    logic signed [15:0]       cf_wdata, dl_wdata;

    logic                     s_req;
    logic [8:0]               s_idx;
    logic signed [15:0]       s_val;
    logic                     s_beat;
    logic [AW-1:0]            wp_inc, rp_dec;

    logic signed [17:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic signed [34:0]       mul_p;
    logic signed [ACC_W-1:0]  prod_ext, rnd15, rnd16;
    logic signed [15:0]       sat15, sat16;

    logic [IP_W:0]            ip1, ip1_next;
    logic                     emit_ok;
    logic [19:0]              ratio_eff;
    logic [POS_W-1:0]         pos_add;
    logic [CW-1:0]            cnt_inc;
    logic                     last_flag;
    logic                     cfg_wr;

    assign s_req  = s_axis_tuser;
    assign s_idx  = {4'b0, s_axis_tdata[4:0]};
    assign s_val  = s_axis_tdata[20:5];
    assign s_beat = s_axis_tvalid && s_axis_tready;

    assign wp_inc = (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + AW'(1);
    assign rp_dec = (r_rp == '0) ? AW'(TAPS - 1) : r_rp - AW'(1);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_INT1: begin
                mul_a = {1'b0, 17'h10000 - {1'b0, r_pos[15:0]}};
                mul_b = {r_prev[15], r_prev};
            end
            ST_INT2: begin
                mul_a = {2'b0, r_pos[15:0]};
                mul_b = {r_cur[15], r_cur};
            end
            default: begin
                mul_a = {{2{r_coef_rd[15]}}, r_coef_rd};
                mul_b = {r_dl_rd[15], r_dl_rd};
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = ACC_W'(r_prod);

    assign rnd15 = (r_acc + RND15) >>> 15;
    assign rnd16 = (r_acc + RND16) >>> 16;
    assign sat15 = (rnd15 > S_MAX) ? 16'sh7fff :
                   (rnd15 < S_MIN) ? 16'sh8000 : rnd15[15:0];
    assign sat16 = (rnd16 > S_MAX) ? 16'sh7fff :
                   (rnd16 < S_MIN) ? 16'sh8000 : rnd16[15:0];

    assign ip1     = {1'b0, r_pos[POS_W-1:16]} + (IP_W + 1)'(1);
    assign emit_ok = (r_cnt < CW'(RESAMPLED_LEN)) &&
                     (ip1 < (IP_W + 1)'(FRAME_LEN)) &&
                     (ip1 == (IP_W + 1)'(r_fidx));

    assign ratio_eff = (r_ratio[19:16] == 4'd0) ? STEP_RATIO_MIN : r_ratio;
    assign pos_add   = r_pos + POS_W'(ratio_eff);
    assign cnt_inc   = r_cnt + CW'(1);
    assign ip1_next  = {1'b0, pos_add[POS_W-1:16]} + (IP_W + 1)'(1);
    assign last_flag = (cnt_inc >= CW'(RESAMPLED_LEN)) ||
                       (ip1_next >= (IP_W + 1)'(FRAME_LEN));

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_rd_vld   = 1'b0;
        n_prod_vld = 1'b0;
        n_acc      = r_acc;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_fidx     = r_fidx;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_enable   = r_enable;
        n_ratio    = r_ratio;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        cf_we      = 1'b0;
        cf_waddr   = s_idx[AW-1:0];
        cf_wdata   = s_val;
        dl_we      = 1'b0;
        dl_waddr   = wp_inc;
        dl_wdata   = s_val;

        if (cfg_wr) begin
            case (paddr[2])
                REG_ENABLE:     n_enable = pwdata[0];
                REG_STEP_RATIO: n_ratio  = pwdata[19:0];
                default:        n_enable = r_enable;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                cf_we    = 1'b1;
                cf_waddr = r_k[AW-1:0];
                cf_wdata = '0;
                dl_we    = 1'b1;
                dl_waddr = r_k[AW-1:0];
                dl_wdata = '0;
                n_k      = r_k + KW'(1);
                if (r_k == KW'(TAPS - 1)) begin
                    n_k     = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_req == REQ_COEF) begin
                        cf_we = (s_idx < 9'(TAPS));
                    end else if (r_enable) begin
                        dl_we   = 1'b1;
                        n_wp    = wp_inc;
                        n_rp    = wp_inc;
                        n_k     = '0;
                        n_acc   = '0;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                n_prod_vld = r_rd_vld;
                if (r_prod_vld) begin
                    n_acc = r_acc + prod_ext;
                end
                if (r_k < KW'(TAPS)) begin
                    n_k      = r_k + KW'(1);
                    n_rp     = rp_dec;
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld && !r_prod_vld) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_cur   = sat15;
                n_state = emit_ok ? ST_INT1 : ST_FIN;
            end
            ST_INT1: begin
                n_state = ST_INT2;
            end
            ST_INT2: begin
                n_acc   = prod_ext;
                n_state = ST_INT3;
            end
            ST_INT3: begin
                n_acc   = r_acc + prod_ext;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = sat16;
                    n_m_last  = last_flag;
                    n_cnt     = cnt_inc;
                    n_pos     = pos_add;
                    n_state   = ST_FIN;
                end
            end
            ST_FIN: begin
                n_prev = r_cur;
                if (r_fidx == FW'(FRAME_LEN - 1)) begin
                    n_fidx = '0;
                    n_pos  = '0;
                    n_cnt  = '0;
                end else begin
                    n_fidx = r_fidx + FW'(1);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_k        <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_prev     <= '0;
            r_fidx     <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_enable   <= ENABLE_RST;
            r_ratio    <= STEP_RATIO_RST;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_rd_vld   <= n_rd_vld;
            r_prod_vld <= n_prod_vld;
            r_prev     <= n_prev;
            r_fidx     <= n_fidx;
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_enable   <= n_enable;
            r_ratio    <= n_ratio;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_prod   <= mul_p;
        r_cur    <= n_cur;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    // coefficient and delay line memories
    always_ff @(posedge i_clk) begin
        if (cf_we) begin
            r_coef_mem[cf_waddr] <= cf_wdata;
        end
        r_coef_rd <= r_coef_mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_mem[dl_waddr] <= dl_wdata;
        end
        r_dl_rd <= r_dl_mem[r_rp];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEP_RATIO) ? {12'b0, r_ratio} : {31'b0, r_enable};

endmodule

[tb/sv/tb_fir_lowpass_linear_resampler_top.sv]
// ----------------------------------------------------------------------------
// tb_fir_lowpass_linear_resampler_top
// self-checking bench for the fir low-pass filter and linear resampler: sample
// and coefficient beats go in with random gaps, every output beat is compared
// with a cycle-free prediction of the filter, rounding, framing and
// interpolation, across several enable and step ratio settings written by apb
// ----------------------------------------------------------------------------
module tb_fir_lowpass_linear_resampler_top
    import flr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS          = TAPS_DEF;
    localparam int FRAME_LEN     = FRAME_LEN_DEF;
    localparam int RESAMPLED_LEN = RESAMPLED_LEN_DEF;
    localparam int DRAIN_CYCLES  = TAPS + 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;

    localparam logic [2:0] ADDR_ENABLE     = {REG_ENABLE, 2'b00};
    localparam logic [2:0] ADDR_STEP_RATIO = {REG_STEP_RATIO, 2'b00};

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_resampled;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic signed [15:0] coef_mem  [TAPS];
    logic signed [15:0] delay_mem [TAPS];
    logic signed [15:0] prev_filt;
    int                 frame_pos;
    logic [31:0]        out_pos;
    int                 out_cnt;
    logic               cfg_enable;
    logic [19:0]        cfg_ratio;

    t_resampled resampled_queue[$];
    int         errors    = 0;
    int         sink_hold = 0;
    bit         no_idle   = 1'b0;
    int         idle_cycles = 0;

    fir_lowpass_linear_resampler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic clear_prediction();
        for (int k = 0; k < TAPS; k++) begin
            coef_mem[k]  = '0;
            delay_mem[k] = '0;
        end
        prev_filt  = '0;
        frame_pos  = 0;
        out_pos    = '0;
        out_cnt    = 0;
        cfg_enable = ENABLE_RST;
        cfg_ratio  = STEP_RATIO_RST;
    endtask

    task automatic predict_beat(input logic req, input logic [4:0] idx,
                                input logic [15:0] val);
        longint             acc;
        longint             mix;
        longint             frac;
        logic signed [15:0] cur;
        logic [31:0]        ratio;
        t_resampled         res;
        if (req == REQ_COEF) begin
            if (idx < TAPS) begin
                coef_mem[idx] = val;
            end
            return;
        end
        if (!cfg_enable) begin
            return;
        end
        for (int k = TAPS - 1; k > 0; k--) begin
            delay_mem[k] = delay_mem[k-1];
        end
        delay_mem[0] = val;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(coef_mem[k]) * longint'(delay_mem[k]);
        end
        cur = sat16((acc + 16384) >>> 15);

        if (out_cnt < RESAMPLED_LEN) begin
            if ((out_pos >> 16) + 1 < FRAME_LEN && (out_pos >> 16) + 1 == frame_pos) begin
                frac  = longint'(out_pos[15:0]);
                mix   = (65536 - frac) * longint'(prev_filt) + frac * longint'(cur);
                ratio = (cfg_ratio < STEP_RATIO_MIN) ? 32'(STEP_RATIO_MIN) : 32'(cfg_ratio);
                out_cnt++;
                out_pos += ratio;
                res.sample = sat16((mix + 32768) >>> 16);
                res.last   = (out_cnt >= RESAMPLED_LEN) || ((out_pos >> 16) + 1 >= FRAME_LEN);
                resampled_queue.push_back(res);
            end
        end

        prev_filt = cur;
        frame_pos++;
        if (frame_pos >= FRAME_LEN) begin
            frame_pos = 0;
            out_pos   = '0;
            out_cnt   = 0;
        end
    endtask

    task automatic send_beat(input logic req, input logic [4:0] idx, input logic [15:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'b000, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_beat(req, idx, val);
    endtask

    task automatic send_random(input int coef_pct);
        logic        req;
        logic [15:0] val;
        req = ($urandom_range(0, 99) < coef_pct) ? REQ_COEF : REQ_SAMPLE;
        val = rand_value();
        if (req == REQ_COEF && $urandom_range(0, 1) == 1) begin
            val = $signed(val) >>> $urandom_range(1, 6);
        end
        send_beat(req, 5'($urandom_range(0, 31)), val);
    endtask

    task automatic sender_idle();
        s_axis_tvalid <= 1'b0;
    endtask

    // waits for every expected beat, then for a silent sample still in flight
    task automatic wait_drained();
        while (resampled_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENABLE) begin
            cfg_enable = data[0];
        end else if (addr == ADDR_STEP_RATIO) begin
            cfg_ratio = data[19:0];
        end
    endtask

    task automatic set_ratio(input logic [19:0] ratio);
        apb_write(ADDR_STEP_RATIO, {12'($urandom()), ratio});
    endtask

    task automatic set_enable(input logic en);
        apb_write(ADDR_ENABLE, {31'($urandom()), en});
    endtask

    task automatic test_directed_extremes();
        send_beat(REQ_SAMPLE, 5'd0, 16'h7FFF);
        send_beat(REQ_COEF, 5'd0, 16'h7FFF);
        send_beat(REQ_COEF, 5'd1, 16'h7FFF);
        send_beat(REQ_COEF, 5'd2, 16'h7FFF);
        send_beat(REQ_COEF, 5'd31, 16'h8000);
        send_beat(REQ_COEF, 5'd15, 16'hFFFF);
        send_beat(REQ_COEF, 5'd16, 16'h0001);
        // positive then negative saturation of the filter sum
        repeat (3) send_beat(REQ_SAMPLE, 5'd31, 16'h7FFF);
        repeat (3) send_beat(REQ_SAMPLE, 5'd0, 16'h8000);
        send_beat(REQ_SAMPLE, 5'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 5'd0, 16'hFFFF);
        send_beat(REQ_SAMPLE, 5'd0, 16'h0001);
        send_beat(REQ_SAMPLE, 5'd0, 16'h5555);
        send_beat(REQ_SAMPLE, 5'd0, 16'hAAAA);
        sender_idle();
        wait_drained();
    endtask

    task automatic test_disabled();
        set_enable(1'b0);
        send_beat(REQ_SAMPLE, 5'd0, 16'h1234);
        send_beat(REQ_COEF, 5'd4, 16'hCFC7);
        send_beat(REQ_SAMPLE, 5'd0, 16'h8000);
        send_beat(REQ_SAMPLE, 5'd0, 16'h7FFF);
        sender_idle();
        wait_drained();
        set_enable(1'b1);
        send_beat(REQ_SAMPLE, 5'd0, 16'h4000);
        send_beat(REQ_SAMPLE, 5'd0, 16'hC000);
        sender_idle();
        wait_drained();
    endtask

    // large steps run past the frame end before the frame closes
    task automatic test_max_ratio();
        set_ratio(20'hFFFFF);
        repeat (40) send_random(5);
        while (frame_pos != 0) send_random(5);
        sender_idle();
        wait_drained();
    endtask

    // one output per sample until the per-frame count runs out
    task automatic test_unit_ratio();
        set_ratio(20'h00000);
        sink_hold = LONG_HOLD;
        repeat (130) send_random(5);
        sender_idle();
        wait_drained();
    endtask

    task automatic test_mixed_ratios();
        logic [19:0] ratio;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       ratio = STEP_RATIO_MIN;
                1:       ratio = 20'($urandom_range(0, 65535));
                default: ratio = 20'($urandom_range(65536, 1048575));
            endcase
            set_ratio(ratio);
            no_idle = (p == 3);
            repeat (14) send_random(10);
            sender_idle();
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // sink side ready pattern, with an occasional long hold-off on request
    initial begin : sink_ready
        int n;
        forever begin
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_resampled want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (resampled_queue.size() == 0) begin
                $display("%0t: unexpected beat got %h last %b", $realtime,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = resampled_queue.pop_front();
                if (m_axis_tdata !== want.sample) begin
                    $display("%0t: sample mismatch exp %h got %h", $realtime,
                             want.sample, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last mismatch exp %b got %b", $realtime,
                             want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        clear_prediction();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_disabled();
        test_max_ratio();
        test_unit_ratio();
        test_mixed_ratios();
        wait_drained();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
